// ===== rtl/rsc_pkg.sv =====
// Shared types and constants for the RPN stack calculator.
`timescale 1ns / 1ps
`default_nettype none

package rsc_pkg;

    // Token codes carried in the mode field
    localparam logic [3:0] MODE_PUSH  = 4'd0;
    localparam logic [3:0] MODE_PEEK  = 4'd1;
    localparam logic [3:0] MODE_DUMP  = 4'd2;
    localparam logic [3:0] MODE_CLEAR = 4'd3;
    localparam logic [3:0] MODE_ABS   = 4'd4;
    localparam logic [3:0] MODE_NEG   = 4'd5;
    localparam logic [3:0] MODE_DUP   = 4'd6;
    localparam logic [3:0] MODE_ADD   = 4'd7;
    localparam logic [3:0] MODE_SUB   = 4'd8;
    localparam logic [3:0] MODE_MUL   = 4'd9;
    localparam logic [3:0] MODE_DIV   = 4'd10;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_ONE     = 3'd2;
    localparam logic [2:0] ST_DIVZERO = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    // Dump prints at most this many entries
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS);

    // Reported depth saturates here
    localparam logic [7:0] DEPTH_OUT_MAX = 8'd63;

    typedef struct packed {
        logic [3:0]         mode;
        logic signed [31:0] operand;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               has_value;
        logic [2:0]         status;
        logic [5:0]         depth_now;
        logic               last;
    } out_word_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_TOP,
        S_SEC,
        S_DIV,
        S_WB,
        S_DUMP,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/rsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rpn_stack_calculator.sv =====
// Top level of the RPN stack calculator: control sequencer and stack RAM.
// The divider produces one quotient bit per cycle; a dump emits one word per cycle
// while the output register is not stalled.
// Throughput: one item at a time; the next item is taken once the last result
// word of the current one is loaded into the output register.
// Time per item is set by the single read port of the stack RAM and the bit-serial divider.
// Reset clears the depth (empty stack) and control state; RAM contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module rpn_stack_calculator
    import rsc_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_word_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_word_t      out_data
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);

    state_t state_reg, state_next;

    logic [3:0]       mode_reg, mode_next;
    logic [31:0]      operand_reg, operand_next;
    logic [DW-1:0]    depth_reg, depth_next;
    logic [31:0]      top_reg, top_next;
    logic [31:0]      res_reg, res_next;
    logic [31:0]      o_value_reg, o_value_next;
    logic             o_has_reg, o_has_next;
    logic [2:0]       o_status_reg, o_status_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [31:0]      div_q_reg, div_q_next;
    logic [31:0]      div_r_reg, div_r_next;
    logic [31:0]      div_d_reg, div_d_next;
    logic             div_neg_reg, div_neg_next;
    logic [4:0]       div_cnt_reg, div_cnt_next;
    logic             out_valid_reg, out_valid_next;
    out_word_t        out_data_reg, out_data_next;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0]   mem_wdata, mem_rdata;

    logic          accept;
    logic          slot_free;
    logic          out_load;
    out_word_t     out_word;
    logic [2:0]    chk_status;
    logic          is_binary;
    logic          needs_read;
    logic [7:0]    depth_wide;
    logic [5:0]    depth_rep;
    logic [32:0]   div_shift;
    logic [32:0]   div_diff;
    logic          div_ge;
    logic [31:0]   div_result;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign is_binary  = mode_reg inside {MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV};
    assign needs_read = (mode_reg inside {MODE_PEEK, MODE_DUMP, MODE_ABS, MODE_NEG, MODE_DUP})
                        || is_binary;

    // Saturate reported depth
    assign depth_wide = 8'(depth_reg);
    assign depth_rep  = (depth_wide > DEPTH_OUT_MAX) ? 6'(DEPTH_OUT_MAX) : depth_wide[5:0];

    // Screen the item against the current depth
    always_comb
    begin
        chk_status = ST_OK;
        case (mode_reg)
            MODE_PUSH:
            begin
                if (depth_reg >= DW'(STACK_DEPTH))
                    chk_status = ST_FULL;
            end
            MODE_PEEK, MODE_DUMP, MODE_ABS, MODE_NEG:
            begin
                if (depth_reg == '0)
                    chk_status = ST_EMPTY;
            end
            MODE_DUP:
            begin
                if (depth_reg == '0)
                    chk_status = ST_EMPTY;
                else if (depth_reg >= DW'(STACK_DEPTH))
                    chk_status = ST_FULL;
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV:
            begin
                if (depth_reg == '0)
                    chk_status = ST_EMPTY;
                else if (depth_reg == DW'(1))
                    chk_status = ST_ONE;
            end
            default:
            begin
                chk_status = ST_OK;
            end
        endcase
    end

    // One restoring divide step on magnitudes
    assign div_shift  = {div_r_reg, div_q_reg[31]};
    assign div_diff   = div_shift - {1'b0, div_d_reg};
    assign div_ge     = !div_diff[32];
    assign div_result = div_neg_reg ? (32'd0 - div_q_reg) : div_q_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (chk_status != ST_OK || !needs_read)
                    state_next = S_EMIT;
                else if (mode_reg == MODE_DUMP)
                    state_next = S_DUMP;
                else
                    state_next = S_TOP;
            end
            S_TOP:
            begin
                state_next = is_binary ? S_SEC : S_EMIT;
            end
            S_SEC:
            begin
                if (mode_reg == MODE_DIV)
                    state_next = (top_reg == 32'd0) ? S_EMIT : S_DIV;
                else
                    state_next = S_WB;
            end
            S_DIV:
            begin
                if (div_cnt_reg == 5'd31)
                    state_next = S_WB;
            end
            S_WB:
            begin
                state_next = S_EMIT;
            end
            S_DUMP:
            begin
                if (slot_free && rem_reg == '0)
                    state_next = S_IDLE;
            end
            S_EMIT:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, RAM control and result word
    always_comb
    begin
        mode_next     = mode_reg;
        operand_next  = operand_reg;
        depth_next    = depth_reg;
        top_next      = top_reg;
        res_next      = res_reg;
        o_value_next  = o_value_reg;
        o_has_next    = o_has_reg;
        o_status_next = o_status_reg;
        rd_ptr_next   = rd_ptr_reg;
        rem_next      = rem_reg;
        div_q_next    = div_q_reg;
        div_r_next    = div_r_reg;
        div_d_next    = div_d_reg;
        div_neg_next  = div_neg_reg;
        div_cnt_next  = div_cnt_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = '0;
        out_load      = 1'b0;
        out_word      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next    = in_data.mode;
                    operand_next = in_data.operand;
                end
            end
            S_CHECK:
            begin
                o_value_next  = 32'd0;
                o_has_next    = 1'b0;
                o_status_next = chk_status;
                if (chk_status == ST_OK)
                begin
                    if (mode_reg == MODE_PUSH)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = AW'(depth_reg);
                        mem_wdata  = operand_reg;
                        depth_next = depth_reg + DW'(1);
                    end
                    else if (mode_reg == MODE_CLEAR)
                    begin
                        depth_next = '0;
                    end
                    else if (needs_read)
                    begin
                        // Fetch the top entry
                        mem_re      = 1'b1;
                        mem_raddr   = AW'(depth_reg - DW'(1));
                        rd_ptr_next = AW'(depth_reg - DW'(1));
                        rem_next    = (depth_wide > 8'(MAX_RESULTS)) ?
                                      CNT_W'(MAX_RESULTS - 1) : CNT_W'(depth_wide - 8'd1);
                    end
                end
            end
            S_TOP:
            begin
                top_next = mem_rdata;
                case (mode_reg)
                    MODE_PEEK:
                    begin
                        o_value_next = mem_rdata;
                        o_has_next   = 1'b1;
                    end
                    MODE_ABS, MODE_NEG:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(depth_reg - DW'(1));
                        if (mode_reg == MODE_NEG || mem_rdata[31])
                            mem_wdata = 32'd0 - mem_rdata;
                        else
                            mem_wdata = mem_rdata;
                    end
                    MODE_DUP:
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = AW'(depth_reg);
                        mem_wdata  = mem_rdata;
                        depth_next = depth_reg + DW'(1);
                    end
                    default:
                    begin
                        // Binary operator: fetch the second entry
                        mem_re    = 1'b1;
                        mem_raddr = AW'(depth_reg - DW'(2));
                    end
                endcase
            end
            S_SEC:
            begin
                case (mode_reg)
                    MODE_ADD: res_next = mem_rdata + top_reg;
                    MODE_SUB: res_next = mem_rdata - top_reg;
                    MODE_MUL: res_next = 32'(mem_rdata * top_reg);
                    default:
                    begin
                        if (top_reg == 32'd0)
                        begin
                            o_status_next = ST_DIVZERO;
                        end
                        else
                        begin
                            // Load the divider with magnitudes
                            div_q_next   = mem_rdata[31] ? (32'd0 - mem_rdata) : mem_rdata;
                            div_d_next   = top_reg[31] ? (32'd0 - top_reg) : top_reg;
                            div_r_next   = 32'd0;
                            div_neg_next = mem_rdata[31] ^ top_reg[31];
                            div_cnt_next = 5'd0;
                        end
                    end
                endcase
            end
            S_DIV:
            begin
                div_r_next   = div_ge ? div_diff[31:0] : div_shift[31:0];
                div_q_next   = {div_q_reg[30:0], div_ge};
                div_cnt_next = div_cnt_reg + 5'd1;
            end
            S_WB:
            begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(depth_reg - DW'(2));
                mem_wdata  = (mode_reg == MODE_DIV) ? div_result : res_reg;
                depth_next = depth_reg - DW'(1);
            end
            S_DUMP:
            begin
                if (slot_free)
                begin
                    out_load              = 1'b1;
                    out_word.result_value = mem_rdata;
                    out_word.has_value    = 1'b1;
                    out_word.status       = ST_OK;
                    out_word.depth_now    = depth_rep;
                    out_word.last         = (rem_reg == '0);
                    if (rem_reg != '0)
                    begin
                        // Advance to the next entry down
                        mem_re      = 1'b1;
                        mem_raddr   = rd_ptr_reg - AW'(1);
                        rd_ptr_next = rd_ptr_reg - AW'(1);
                        rem_next    = rem_reg - CNT_W'(1);
                    end
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_load              = 1'b1;
                    out_word.result_value = o_value_reg;
                    out_word.has_value    = o_has_reg;
                    out_word.status       = o_status_reg;
                    out_word.depth_now    = depth_rep;
                    out_word.last         = 1'b1;
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // Output register: load a word or drop it once taken
    always_comb
    begin
        out_valid_next = out_load || (out_valid_reg && !out_ready);
        out_data_next  = out_load ? out_word : out_data_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        operand_reg  <= operand_next;
        top_reg      <= top_next;
        res_reg      <= res_next;
        o_value_reg  <= o_value_next;
        o_has_reg    <= o_has_next;
        o_status_reg <= o_status_next;
        rd_ptr_reg   <= rd_ptr_next;
        rem_reg      <= rem_next;
        div_q_reg    <= div_q_next;
        div_r_reg    <= div_r_next;
        div_d_reg    <= div_d_next;
        div_neg_reg  <= div_neg_next;
        div_cnt_reg  <= div_cnt_next;
        out_data_reg <= out_data_next;
    end

    // Stack storage
    rsc_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire
